// ----- rtl/uarttx_pkg.sv -----
// uarttx_pkg: shared constants, codes and control structs for the buffered 8n1 transmitter
// used by uarttx_ctrl, uarttx_dp and uart_tx_buffered_8n1; no dependencies
package uarttx_pkg;

  localparam int BUFFER_DEPTH  = 256;
  localparam int BITS_PER_BYTE = 8;
  // length/pointer counters must hold the depth itself
  localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int BIT_W  = $clog2(BITS_PER_BYTE);

  // item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // an item transfer happens this cycle
    logic start_msg;  // idle tick with a pending message
    logic start_bit;  // start tick
    logic data_bit;   // data tick
    logic stop_bit;   // stop tick
    logic store;      // write byte into the buffer
    logic end_msg;    // last mark closes the message
    logic ignored;    // load refused
    logic busy_next;  // busy flag after this item
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic msg_pending;     // message_length != 0
    logic remaining_zero;  // bytes_remaining == 0
    logic bit_last;        // current data bit is bit 7
    logic load_full;       // load pointer at buffer depth
  } status_t;

endpackage

// ----- rtl/uart_tx_buffered_8n1.sv -----
// uart_tx_buffered_8n1: buffered 8n1 uart transmitter, one bit time per tick item
// latency: one result per item, registered, valid the cycle after the input transfer
// throughput: one item per clock; in_stall rises only while a result waits under out_stall
// reset (rst, synchronous, active high): idle phase, line high, empty buffer, no result held
// buffer contents are not cleared by reset; only written entries are ever sent
// depends on uarttx_pkg, uarttx_ctrl, uarttx_dp
module uart_tx_buffered_8n1 (
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_level,
  output logic       busy_res,
  output logic       load_ignored
);
  import uarttx_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller: phase machine (idle, start, data, stop) and transfer control
  uarttx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: buffer memory, byte fetch on start tick, bit selection, counters, results
  uarttx_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .status       (status),
    .tx_level     (tx_level),
    .busy_res     (busy_res),
    .load_ignored (load_ignored)
  );

endmodule

// ----- rtl/uarttx_dp.sv -----
// uarttx_dp: datapath with message buffer, counters, line level and result registers
// depends on uarttx_pkg
module uarttx_dp (
  input  logic                clk,
  input  logic                rst,
  input  uarttx_pkg::cmd_t    cmd,
  input  logic [7:0]          data_byte,
  output uarttx_pkg::status_t status,
  output logic                tx_level,
  output logic                busy_res,
  output logic                load_ignored
);
  import uarttx_pkg::*;

  logic [7:0]       mem [BUFFER_DEPTH];
  logic [7:0]       rd_byte;
  logic [LEN_W-1:0] message_length;
  logic [LEN_W-1:0] bytes_remaining;
  logic [LEN_W-1:0] load_pointer;
  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] ptr_inc;
  logic [BIT_W-1:0] bit_index;
  logic             line_level;
  logic             line_next;

  assign pos     = message_length - bytes_remaining;
  assign ptr_inc = load_pointer + LEN_W'(1);

  assign status.msg_pending    = (message_length != '0);
  assign status.remaining_zero = (bytes_remaining == '0);
  assign status.bit_last       = (bit_index == BIT_W'(BITS_PER_BYTE - 1));
  assign status.load_full      = (load_pointer == LEN_W'(BUFFER_DEPTH));

  always_comb begin
    priority if (cmd.start_bit) begin
      line_next = 1'b0;
    end else if (cmd.data_bit) begin
      line_next = rd_byte[bit_index];
    end else if (cmd.stop_bit) begin
      line_next = 1'b1;
    end else begin
      line_next = line_level;
    end
  end

  // buffer write on load, byte fetch on start tick
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[load_pointer[ADDR_W-1:0]] <= data_byte;
    end
    if (cmd.start_bit) begin
      rd_byte <= mem[pos[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_length  <= '0;
      bytes_remaining <= '0;
      load_pointer    <= '0;
      bit_index       <= '0;
      line_level      <= 1'b1;
    end else begin
      line_level <= line_next;
      if (cmd.start_msg) begin
        bytes_remaining <= message_length;
      end else if (cmd.data_bit && status.bit_last && !status.remaining_zero) begin
        bytes_remaining <= bytes_remaining - LEN_W'(1);
      end
      if (cmd.start_bit) begin
        bit_index <= '0;
      end else if (cmd.data_bit) begin
        bit_index <= bit_index + BIT_W'(1);
      end
      if (cmd.end_msg) begin
        message_length <= cmd.store ? ptr_inc : load_pointer;
        load_pointer   <= '0;
      end else begin
        if (cmd.stop_bit && status.remaining_zero) begin
          message_length <= '0;
        end
        if (cmd.store) begin
          load_pointer <= ptr_inc;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tx_level     <= line_next;
      busy_res     <= cmd.busy_next;
      load_ignored <= cmd.ignored;
    end
  end

endmodule

// ----- rtl/uarttx_ctrl.sv -----
// uarttx_ctrl: frame phase state machine and item/result handshake control
// depends on uarttx_pkg
module uarttx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  input  uarttx_pkg::status_t status,
  output uarttx_pkg::cmd_t    cmd
);
  import uarttx_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic       accept;
  logic       tick;
  logic       load;
  logic       busy;
  logic       pend_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign tick     = accept && (kind == KIND_TICK);
  assign load     = accept && (kind == KIND_LOAD);
  assign busy     = (phase != PH_IDLE) || status.msg_pending;

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.store     = load && !busy && !status.load_full;
    cmd.end_msg   = load && !busy && last_byte;
    cmd.ignored   = load && (busy || status.load_full);
    phase_next    = phase;
    unique case (phase)
      PH_IDLE: begin
        if (tick && status.msg_pending) begin
          cmd.start_msg = 1'b1;
          phase_next    = PH_START;
        end
      end
      PH_START: begin
        if (tick) begin
          cmd.start_bit = 1'b1;
          phase_next    = PH_DATA;
        end
      end
      PH_DATA: begin
        if (tick) begin
          cmd.data_bit = 1'b1;
          if (status.bit_last) begin
            phase_next = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        if (tick) begin
          cmd.stop_bit = 1'b1;
          phase_next   = status.remaining_zero ? PH_IDLE : PH_START;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    // pending flag after this item, mirrors message_length update
    priority if (cmd.end_msg) begin
      pend_next = 1'b1;
    end else if (cmd.stop_bit && status.remaining_zero) begin
      pend_next = 1'b0;
    end else begin
      pend_next = status.msg_pending;
    end
    cmd.busy_next = (phase_next != PH_IDLE) || pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_active_has_msg: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> status.msg_pending)
    else $error("frame in progress without a message");
  a_no_store_full: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !status.load_full)
    else $error("buffer write beyond depth");
  a_stop_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.stop_bit && status.remaining_zero) |=> (phase == PH_IDLE && !status.msg_pending))
    else $error("last stop bit did not return to idle");
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start_msg, cmd.start_bit, cmd.data_bit, cmd.stop_bit, cmd.store}))
    else $error("more than one datapath step in a cycle");
`endif

endmodule
